>>> sv/lpsm_pkg.sv
// Shared types, codes and default sizes for the linear probe slot map.
`default_nettype none

package lpsm_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int SLOT_LIMIT_DEF    = 1024;
    localparam int KEY_WIDTH_DEF     = 16;

    // Fixed field widths.
    localparam int MODE_W   = 2;
    localparam int KEY_IN_W = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;
    localparam int CNT_W    = 11;

    localparam logic [CNT_W-1:0] MAX_ENT_RESET = 11'd1024;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Classified operation carried from front to back.
    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_ADD,
        OP_CLEAR,
        OP_BAD,
        OP_NONE
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_ADDED     = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_FULL      = 3'd4,
        ST_EXHAUSTED = 3'd5,
        ST_BAD_KEY   = 3'd6,
        ST_CLEARED   = 3'd7
    } t_status;

    typedef struct packed {
        t_op                 op;
        logic [KEY_IN_W-1:0] key;
    } t_cmd;

endpackage

`default_nettype wire

>>> sv/lpsm_front.sv
// Input stage: accept items, mask the key and classify the request.
`default_nettype none

module lpsm_front #(
    parameter int KEY_WIDTH = lpsm_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lpsm_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [lpsm_pkg::KEY_IN_W-1:0] i_key,
    input  wire logic                          i_hold,
    input  wire logic                          i_full,
    output logic                               o_push,
    output lpsm_pkg::t_cmd                     o_cmd
);

    localparam logic [lpsm_pkg::KEY_IN_W-1:0] KEY_MASK =
        (KEY_WIDTH >= lpsm_pkg::KEY_IN_W) ? '1
                                          : lpsm_pkg::KEY_IN_W'((32'd1 << KEY_WIDTH) - 32'd1);

    logic                              r_valid;
    lpsm_pkg::t_cmd                    r_cmd;
    lpsm_pkg::t_cmd                    n_cmd;
    logic [lpsm_pkg::KEY_IN_W-1:0]     key_m;
    logic                              accept;

    assign key_m   = i_key & KEY_MASK;
    assign o_push  = r_valid && !i_full;
    assign o_ready = !i_hold && (!r_valid || !i_full);
    assign accept  = i_valid && o_ready;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.key = key_m;
        case (i_mode)
            lpsm_pkg::MODE_LOOKUP: begin
                n_cmd.op = (key_m == '0) ? lpsm_pkg::OP_BAD : lpsm_pkg::OP_LOOKUP;
            end
            lpsm_pkg::MODE_ADD: begin
                n_cmd.op = (key_m == '0) ? lpsm_pkg::OP_BAD : lpsm_pkg::OP_ADD;
            end
            lpsm_pkg::MODE_CLEAR: begin
                n_cmd.op = lpsm_pkg::OP_CLEAR;
            end
            default: begin
                n_cmd.op = lpsm_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/lpsm_fifo.sv
// Short command queue between the front and back stages.
`default_nettype none

module lpsm_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lpsm_pkg::t_cmd i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output lpsm_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);

    localparam int CNT_BITS = $clog2(lpsm_pkg::Q_DEPTH + 1);

    lpsm_pkg::t_cmd                   r_entries [lpsm_pkg::Q_DEPTH];
    logic [lpsm_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [lpsm_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [CNT_BITS-1:0]              r_count;
    logic                             do_pop;

    assign o_full  = (r_count == CNT_BITS'(lpsm_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entries[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/lpsm_back.sv
// Probe engine: table memory, slot allocation, clearing sweeps and result register.
`default_nettype none

module lpsm_back #(
    parameter int TABLE_ENTRIES = lpsm_pkg::TABLE_ENTRIES_DEF,
    parameter int SLOT_LIMIT    = lpsm_pkg::SLOT_LIMIT_DEF,
    parameter int KEY_WIDTH     = lpsm_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lpsm_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_q_valid,
    input  wire lpsm_pkg::t_cmd                i_q_cmd,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [lpsm_pkg::STATUS_W-1:0]      o_status,
    output logic [lpsm_pkg::SLOT_W-1:0]        o_entity_slot,
    output logic                               o_init_busy
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int ENT_W = KEY_WIDTH + lpsm_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_CLEAR
    } t_state;

    t_state                          r_state, n_state;
    logic [IDX_W-1:0]                r_addr, n_addr;
    logic [IDX_W-1:0]                r_count, n_count;
    logic [KEY_WIDTH-1:0]            r_key, n_key;
    logic                            r_is_add, n_is_add;
    logic [lpsm_pkg::CNT_W-1:0]      r_used, n_used;
    logic [lpsm_pkg::CNT_W-1:0]      r_max;
    logic                            r_out_valid, n_out_valid;
    lpsm_pkg::t_status               r_status, n_status;
    logic [lpsm_pkg::SLOT_W-1:0]     r_slot, n_slot;

    // Table entry: stored key above its slot number; key zero marks empty.
    logic [ENT_W-1:0]                mem [TABLE_ENTRIES];
    logic [ENT_W-1:0]                r_rd_data;
    logic [IDX_W-1:0]                rd_addr;
    logic                            we;
    logic [IDX_W-1:0]                wr_addr;
    logic [ENT_W-1:0]                wr_data;

    logic [KEY_WIDTH-1:0]            rd_key;
    logic [lpsm_pkg::SLOT_W-1:0]     rd_slot;
    logic [lpsm_pkg::CNT_W-1:0]      limit;
    logic                            out_free;

    assign rd_key        = r_rd_data[ENT_W-1:lpsm_pkg::SLOT_W];
    assign rd_slot       = r_rd_data[lpsm_pkg::SLOT_W-1:0];
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entity_slot = r_slot;
    assign o_init_busy   = (r_state == S_INIT);

    always_comb begin
        if (32'(r_max) > 32'(SLOT_LIMIT)) begin
            limit = lpsm_pkg::CNT_W'(SLOT_LIMIT);
        end else begin
            limit = r_max;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_count     = r_count;
        n_key       = r_key;
        n_is_add    = r_is_add;
        n_used      = r_used;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_slot      = r_slot;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        wr_addr     = r_addr;
        wr_data     = '0;
        rd_addr     = r_addr + 1'b1;

        case (r_state)
            S_INIT: begin
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = IDX_W'(i_q_cmd.key);
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.op)
                        lpsm_pkg::OP_LOOKUP, lpsm_pkg::OP_ADD: begin
                            n_key    = KEY_WIDTH'(i_q_cmd.key);
                            n_is_add = (i_q_cmd.op == lpsm_pkg::OP_ADD);
                            n_addr   = IDX_W'(i_q_cmd.key);
                            n_count  = '0;
                            n_state  = S_CHECK;
                        end
                        lpsm_pkg::OP_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLEAR;
                        end
                        lpsm_pkg::OP_BAD: begin
                            n_out_valid = 1'b1;
                            n_status    = lpsm_pkg::ST_BAD_KEY;
                            n_slot      = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = lpsm_pkg::ST_NOT_FOUND;
                            n_slot      = '0;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // Read data holds the entry at r_addr; the next entry is read meanwhile.
                if (rd_key == r_key) begin
                    n_out_valid = 1'b1;
                    n_status    = r_is_add ? lpsm_pkg::ST_PRESENT : lpsm_pkg::ST_FOUND;
                    n_slot      = rd_slot;
                    n_state     = S_IDLE;
                end else if (rd_key == '0) begin
                    n_out_valid = 1'b1;
                    n_slot      = '0;
                    n_state     = S_IDLE;
                    if (!r_is_add) begin
                        n_status = lpsm_pkg::ST_NOT_FOUND;
                    end else if (r_used < limit) begin
                        we       = 1'b1;
                        wr_data  = {r_key, r_used[lpsm_pkg::SLOT_W-1:0]};
                        n_used   = r_used + 1'b1;
                        n_status = lpsm_pkg::ST_ADDED;
                        n_slot   = r_used[lpsm_pkg::SLOT_W-1:0];
                    end else begin
                        n_status = lpsm_pkg::ST_EXHAUSTED;
                    end
                end else if (r_count == LAST_IDX) begin
                    n_out_valid = 1'b1;
                    n_status    = r_is_add ? lpsm_pkg::ST_FULL : lpsm_pkg::ST_NOT_FOUND;
                    n_slot      = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            S_CLEAR: begin
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_used      = '0;
                    n_out_valid = 1'b1;
                    n_status    = lpsm_pkg::ST_CLEARED;
                    n_slot      = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_count     <= '0;
            r_used      <= '0;
            r_max       <= lpsm_pkg::MAX_ENT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_is_add <= n_is_add;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/linear_probe_slot_map.sv
// Top level of the linear probe slot map: front stage, command queue and probe engine.
//
// Input channel (i_valid/o_ready) takes one item: i_mode (lookup, add, clear) and i_key.
// Output channel (o_valid/i_ready) returns one item per input: o_status, o_entity_slot.
// Configuration: i_cfg_we writes i_cfg_wdata into max_entities at once, no wait.
// Path from input accept to o_valid: front-stage register, command queue, probe engine
// and its result register. A zero key or unused mode is answered without a table read;
// lookup and add read entries from the key's home entry on, one entry per cycle, and
// clear writes every table entry, one entry per cycle. The probe engine has one table
// read port and one write port and works on one item at a time: it pops the next item
// from the queue only when idle with the result register free.
// Reset: a clearing pass writes every table entry, with o_ready low.
// When the receiver stalls, the result register holds; the front stage and a two-item
// queue keep accepting until they fill, then o_ready drops.
`default_nettype none

module linear_probe_slot_map #(
    parameter int TABLE_ENTRIES = lpsm_pkg::TABLE_ENTRIES_DEF,
    parameter int SLOT_LIMIT    = lpsm_pkg::SLOT_LIMIT_DEF,
    parameter int KEY_WIDTH     = lpsm_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lpsm_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [lpsm_pkg::KEY_IN_W-1:0] i_key,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [lpsm_pkg::STATUS_W-1:0]      o_status,
    output logic [lpsm_pkg::SLOT_W-1:0]        o_entity_slot,
    input  wire logic                          i_cfg_we,
    input  wire logic [lpsm_pkg::CNT_W-1:0]    i_cfg_wdata
);

    logic            init_busy;
    logic            q_full;
    logic            q_push;
    lpsm_pkg::t_cmd  front_cmd;
    logic            q_valid;
    lpsm_pkg::t_cmd  q_cmd;
    logic            q_pop;

    // Classify items; hold off while the reset sweep runs.
    lpsm_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_key   (i_key),
        .i_hold  (init_busy),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (front_cmd)
    );

    // Decouple classification from the probe engine.
    lpsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Walk the table, allocate slots, sweep on clear, drive the result register.
    lpsm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SLOT_LIMIT    (SLOT_LIMIT),
        .KEY_WIDTH     (KEY_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .o_status      (o_status),
        .o_entity_slot (o_entity_slot),
        .o_init_busy   (init_busy)
    );

`ifndef SYNTHESIS
    // No item gets in while the reset sweep is writing the table.
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !o_ready)
        else $error("input accepted during reset sweep");

    // Only found, added and already-present results carry a slot number.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != lpsm_pkg::ST_FOUND && o_status != lpsm_pkg::ST_ADDED
         && o_status != lpsm_pkg::ST_PRESENT) |-> (o_entity_slot == '0))
        else $error("nonzero slot on a result without a slot");

    // The engine leaves the reset sweep with no result pending.
    a_init_exit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(init_busy) |-> !o_valid)
        else $error("result pending at end of reset sweep");
`endif

endmodule

`default_nettype wire

>>> sim/linear_probe_slot_map_tb.sv
// Self-checking testbench for linear_probe_slot_map: directed table, then phased random traffic.

module linear_probe_slot_map_tb;

    localparam int TBL   = lpsm_pkg::TABLE_ENTRIES_DEF;
    localparam int IDX_W = $clog2(TBL);

    // Mode 3 is unused by the block; it must answer not found and touch nothing.
    localparam logic [lpsm_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int MAX_GAP    = 16;
    localparam int LONG_HOLD  = 400;
    localparam int HOLD_AT    = 300;
    localparam int REPORT_MAX = 10;
    localparam int N_PHASES   = 6;
    localparam int N_DIRECTED = 27;

    // Longest legal silence: a clear, a probe over a 1024-key chain, the long receiver hold
    // and a few gaps. Allow about four times that.
    localparam int IDLE_LIMIT = 25000;

    typedef struct packed {
        lpsm_pkg::t_status                 status;
        logic [lpsm_pkg::SLOT_W-1:0]       slot;
    } t_answer;

    // One line of the directed table: either a limit write or an item, with an
    // optional hand-written answer.
    typedef struct packed {
        bit                                is_cfg;
        logic [lpsm_pkg::CNT_W-1:0]        cfg_val;
        logic [lpsm_pkg::MODE_W-1:0]       mode;
        logic [lpsm_pkg::KEY_IN_W-1:0]     key;
        bit                                typed;
        t_answer                           want;
    } t_step_row;

    localparam t_answer NO_ANSWER = '{lpsm_pkg::ST_NOT_FOUND, 10'd0};

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic [lpsm_pkg::MODE_W-1:0]         i_mode;
    logic [lpsm_pkg::KEY_IN_W-1:0]       i_key;
    logic                                o_valid;
    logic                                i_ready;
    logic [lpsm_pkg::STATUS_W-1:0]       o_status;
    logic [lpsm_pkg::SLOT_W-1:0]         o_entity_slot;
    logic                                i_cfg_we;
    logic [lpsm_pkg::CNT_W-1:0]          i_cfg_wdata;

    // Mirror of the block: probe table, slot numbers, allocation count, limit.
    logic [lpsm_pkg::KEY_IN_W-1:0]       key_tab [TBL];
    logic [lpsm_pkg::SLOT_W-1:0]         slot_tab [TBL];
    logic [lpsm_pkg::CNT_W-1:0]          used_cnt;
    logic [lpsm_pkg::CNT_W-1:0]          limit_val;
    logic [lpsm_pkg::KEY_IN_W-1:0]       live_keys [$];

    t_answer                             pending_answers [$];
    t_step_row                           directed_rows [N_DIRECTED];
    logic [lpsm_pkg::CNT_W-1:0]          phase_limits [N_PHASES];
    int                                  phase_items [N_PHASES];
    logic [IDX_W-1:0]                    hot_bases [4];

    int calm_left [2]   = '{0, 0};
    int status_seen [8] = '{default: 0};
    int items_in        = 0;
    int answers_out     = 0;
    int limit_writes    = 0;
    int mismatch_cnt    = 0;
    int idle_cycles     = 0;
    bit long_hold_done  = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    linear_probe_slot_map dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entity_slot (o_entity_slot),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Empty the probe table and restart slot allocation; slot numbers stay behind.
    function automatic void wipe_keys();
        for (int i = 0; i < TBL; i++) key_tab[i] = '0;
        used_cnt = '0;
        live_keys.delete();
    endfunction

    // Work out the answer to one item and advance the mirrored state.
    function automatic t_answer slot_map_predict(logic [lpsm_pkg::MODE_W-1:0] mode,
                                                 logic [lpsm_pkg::KEY_IN_W-1:0] key);
        t_answer                      ans;
        logic [IDX_W-1:0]             idx;
        logic [IDX_W-1:0]             spot;
        logic [lpsm_pkg::CNT_W-1:0]   eff_limit;
        bit                           hit;
        bit                           empty;
        ans   = NO_ANSWER;
        hit   = 1'b0;
        empty = 1'b0;
        spot  = '0;
        if (mode == lpsm_pkg::MODE_CLEAR) begin
            wipe_keys();
            ans.status = lpsm_pkg::ST_CLEARED;
        end else if (mode == lpsm_pkg::MODE_LOOKUP || mode == lpsm_pkg::MODE_ADD) begin
            if (key == '0) begin
                ans.status = lpsm_pkg::ST_BAD_KEY;
            end else begin
                // Walk from the home entry, one step at a time, wrapping at the top.
                for (int n = 0; n < TBL; n++) begin
                    idx = key[IDX_W-1:0] + IDX_W'(n);
                    if (key_tab[idx] == key) begin
                        hit  = 1'b1;
                        spot = idx;
                        break;
                    end
                    if (key_tab[idx] == '0) begin
                        empty = 1'b1;
                        spot  = idx;
                        break;
                    end
                end
                // A limit above the slot range is clamped to it.
                eff_limit = (limit_val > lpsm_pkg::CNT_W'(lpsm_pkg::SLOT_LIMIT_DEF))
                          ? lpsm_pkg::CNT_W'(lpsm_pkg::SLOT_LIMIT_DEF) : limit_val;
                if (hit) begin
                    ans.slot   = slot_tab[spot];
                    ans.status = (mode == lpsm_pkg::MODE_LOOKUP) ? lpsm_pkg::ST_FOUND
                                                                 : lpsm_pkg::ST_PRESENT;
                end else if (mode == lpsm_pkg::MODE_LOOKUP) begin
                    ans.status = lpsm_pkg::ST_NOT_FOUND;
                end else if (!empty) begin
                    ans.status = lpsm_pkg::ST_FULL;
                end else if (used_cnt < eff_limit) begin
                    ans.slot       = used_cnt[lpsm_pkg::SLOT_W-1:0];
                    key_tab[spot]  = key;
                    slot_tab[spot] = ans.slot;
                    used_cnt       = used_cnt + 1'b1;
                    live_keys.push_back(key);
                    ans.status     = lpsm_pkg::ST_ADDED;
                end else begin
                    ans.status = lpsm_pkg::ST_EXHAUSTED;
                end
            end
        end
        return ans;
    endfunction

    // Draw a wait for one side (0 sender, 1 receiver); now and then run a
    // stretch with no waits at all.
    function automatic int draw_gap(int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one item at a falling edge, hold it until taken, then queue its answer.
    // A typed answer replaces the predicted one; the mirror advances either way.
    task automatic offer(logic [lpsm_pkg::MODE_W-1:0] mode,
                         logic [lpsm_pkg::KEY_IN_W-1:0] key,
                         bit typed, t_answer want);
        int      gap;
        t_answer model_ans;
        gap = draw_gap(0);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode  = mode;
        i_key   = key;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        model_ans = slot_map_predict(mode, key);
        pending_answers.push_back(typed ? want : model_ans);
        items_in++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every queued answer has come back.
    task automatic settle();
        i_valid = 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
    endtask

    // Write the slot limit; call only while the block is idle.
    task automatic write_limit(logic [lpsm_pkg::CNT_W-1:0] val);
        i_cfg_wdata = val;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        limit_val   = val;
        limit_writes++;
    endtask

    // Receiver: stall at random, once for a long stretch so the block backs up
    // and drops o_ready; compare each answer with the oldest expectation.
    initial begin
        int      gap;
        t_answer want;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && answers_out >= HOLD_AT) begin
                gap            = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                gap = draw_gap(1);
            end
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            answers_out++;
            if (!$isunknown(o_status)) status_seen[o_status]++;
            if (pending_answers.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("[%0t] unexpected answer: status %0d slot %0d",
                             $realtime, o_status, o_entity_slot);
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status || o_entity_slot !== want.slot) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display({"[%0t] answer %0d: expected %s slot %0d,",
                                  " got status %0d slot %0d"},
                                 $realtime, answers_out, want.status.name(), want.slot,
                                 o_status, o_entity_slot);
                end
            end
            @(negedge i_clk);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d answers outstanding",
                     IDLE_LIMIT, pending_answers.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sender: reset, directed table, then phases of random items.
    initial begin
        int                              pick;
        int                              kpick;
        bit                              filling;
        logic [lpsm_pkg::MODE_W-1:0]     mode;
        logic [lpsm_pkg::KEY_IN_W-1:0]   key;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = lpsm_pkg::MODE_LOOKUP;
        i_key       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        limit_val   = lpsm_pkg::MAX_ENT_RESET;
        wipe_keys();

        // Keys sharing these low bits pile up in long chains; the top one wraps.
        hot_bases    = '{12'h000, 12'h7FE, 12'hFFE, 12'h5A5};
        // Fill to the slot clamp first, then tight and default limits.
        phase_limits = '{11'd2047, 11'd0, 11'd1, 11'd1024, 11'd13, 11'd0};
        phase_items  = '{1150, 12, 12, 12, 12, 12};

        // Directed rows: zero key, miss, add, re-add, hit, a collision chain,
        // a probe that wraps past the top entry, unused mode, clear, and the
        // slot limit running out at limits of one and zero.
        directed_rows = '{
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h0000, 1'b1,
              '{lpsm_pkg::ST_BAD_KEY, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h0000, 1'b1,
              '{lpsm_pkg::ST_BAD_KEY, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h1234, 1'b1,
              '{lpsm_pkg::ST_NOT_FOUND, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h1234, 1'b1,
              '{lpsm_pkg::ST_ADDED, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h1234, 1'b1,
              '{lpsm_pkg::ST_PRESENT, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h1234, 1'b1,
              '{lpsm_pkg::ST_FOUND, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'hFFFF, 1'b1,
              '{lpsm_pkg::ST_ADDED, 10'd1}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h0001, 1'b1,
              '{lpsm_pkg::ST_ADDED, 10'd2}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h1001, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'hF001, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'hF001, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h2001, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, MODE_SPARE, 16'h1234, 1'b1,
              '{lpsm_pkg::ST_NOT_FOUND, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h0FFF, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h0FFF, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_CLEAR, 16'h0000, 1'b1,
              '{lpsm_pkg::ST_CLEARED, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h1234, 1'b1,
              '{lpsm_pkg::ST_NOT_FOUND, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h8000, 1'b1,
              '{lpsm_pkg::ST_ADDED, 10'd0}},
            '{1'b1, 11'd1, lpsm_pkg::MODE_LOOKUP, 16'h0000, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h4444, 1'b1,
              '{lpsm_pkg::ST_EXHAUSTED, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h8000, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h4444, 1'b1,
              '{lpsm_pkg::ST_NOT_FOUND, 10'd0}},
            '{1'b1, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'h0000, 1'b0, NO_ANSWER},
            '{1'b0, 11'd0, lpsm_pkg::MODE_CLEAR, 16'hFFFF, 1'b1,
              '{lpsm_pkg::ST_CLEARED, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_ADD, 16'h0002, 1'b1,
              '{lpsm_pkg::ST_EXHAUSTED, 10'd0}},
            '{1'b0, 11'd0, lpsm_pkg::MODE_LOOKUP, 16'hFFFF, 1'b1,
              '{lpsm_pkg::ST_NOT_FOUND, 10'd0}},
            '{1'b0, 11'd0, MODE_SPARE, 16'h0000, 1'b0, NO_ANSWER}
        };

        // Hold reset; the block then clears its table with o_ready low.
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                settle();
                write_limit(directed_rows[r].cfg_val);
            end else begin
                offer(directed_rows[r].mode, directed_rows[r].key,
                      directed_rows[r].typed, directed_rows[r].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            write_limit((ph == N_PHASES - 1) ? lpsm_pkg::CNT_W'($urandom_range(2, 1023))
                                             : phase_limits[ph]);
            // Start every phase from an empty table so the new limit bites.
            offer(lpsm_pkg::MODE_CLEAR, 16'($urandom), 1'b0, NO_ANSWER);
            filling = (ph == 0);
            for (int n = 0; n < phase_items[ph]; n++) begin
                // Filling phase: nearly all adds of fresh keys, to run past the clamp.
                pick = $urandom_range(0, 99);
                if (filling)
                    mode = (pick < 1) ? MODE_SPARE :
                           (pick < 3) ? lpsm_pkg::MODE_LOOKUP : lpsm_pkg::MODE_ADD;
                else
                    mode = (pick < 2) ? lpsm_pkg::MODE_CLEAR : (pick < 5) ? MODE_SPARE :
                           (pick < 50) ? lpsm_pkg::MODE_LOOKUP : lpsm_pkg::MODE_ADD;

                kpick = $urandom_range(0, 99);
                if (kpick < (filling ? 1 : 5))
                    key = '0;
                else if (kpick < (filling ? 2 : 45) && live_keys.size() != 0)
                    key = live_keys[$urandom_range(0, live_keys.size() - 1)];
                else if (kpick < (filling ? 4 : 65))
                    key = {4'($urandom), hot_bases[$urandom_range(0, 3)]};
                else
                    key = 16'($urandom);

                offer(mode, key, 1'b0, NO_ANSWER);
                // Pause once mid-fill until the block has answered everything.
                if (filling && n == phase_items[ph] / 2) settle();
            end
        end

        settle();
        // Keep the clock running to catch any stray answer.
        repeat (16) @(posedge i_clk);

        $display({"Covered %0d items over %0d limit writes: found %0d, not found %0d,",
                  " added %0d, present %0d,"},
                 items_in, limit_writes, status_seen[lpsm_pkg::ST_FOUND],
                 status_seen[lpsm_pkg::ST_NOT_FOUND], status_seen[lpsm_pkg::ST_ADDED],
                 status_seen[lpsm_pkg::ST_PRESENT]);
        $display("  exhausted %0d, table full %0d, bad key %0d, cleared %0d; %0d mismatches",
                 status_seen[lpsm_pkg::ST_EXHAUSTED], status_seen[lpsm_pkg::ST_FULL],
                 status_seen[lpsm_pkg::ST_BAD_KEY], status_seen[lpsm_pkg::ST_CLEARED],
                 mismatch_cnt);
        if (mismatch_cnt == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
